// File: rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and sample expansion functions for the PCM frame
// to 24-bit stereo converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int RAW_W     = 32;
	localparam int SAMPLE_W  = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 3;

	// Sample format codes
	localparam logic [2:0] FMT_U8   = 3'd0;
	localparam logic [2:0] FMT_S16  = 3'd1;
	localparam logic [2:0] FMT_S24  = 3'd2;
	localparam logic [2:0] FMT_S32  = 3'd3;
	localparam logic [2:0] FMT_ALAW = 3'd4;
	localparam logic [2:0] FMT_ULAW = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEREO = 2'd1;

	localparam logic [2:0] FMT_RESET    = FMT_S16;
	localparam logic       STEREO_RESET = 1'b1;

	localparam logic [7:0] U8_OFFSET = 8'h80;

	typedef struct packed {
		logic [2:0] sample_format;
		logic       stereo_mode;
	} cfg_t;

	// G.711 A-law code to 16-bit linear
	function automatic logic [15:0] alaw_expand(input logic [7:0] code);
		logic [7:0]  a;
		logic [2:0]  seg;
		logic [15:0] mag;
		begin
			a   = code ^ 8'h55;
			seg = a[6:4];
			mag = {8'd0, a[3:0], 4'd0};
			if (seg == 3'd0) begin
				mag = mag + 16'h0008;
			end else begin
				mag = (mag + 16'h0108) << (seg - 3'd1);
			end
			alaw_expand = a[7] ? mag : (16'd0 - mag);
		end
	endfunction

	// G.711 mu-law code to 16-bit linear
	function automatic logic [15:0] ulaw_expand(input logic [7:0] code);
		logic [7:0]  u;
		logic [15:0] mag;
		begin
			u   = ~code;
			mag = ({9'd0, u[3:0], 3'd0} + 16'h0084) << u[6:4];
			ulaw_expand = u[7] ? (16'h0084 - mag) : (mag - 16'h0084);
		end
	endfunction

endpackage

// File: rtl/pcm_frame_to_24bit_stereo.sv
// ----------------------------------------------------------------------------
// pcm_frame_to_24bit_stereo
// Converts raw PCM frames to 24-bit signed stereo frames.
//
// Usage:
//   Input channel (in_valid/in_ready, left_raw, right_raw) takes one raw
//   frame per transaction; output channel (out_valid/out_ready, left_out,
//   right_out) gives one 24-bit stereo frame per transaction.
//   Frames pass through an input register and a result register with the
//   format conversion between them: out_valid rises once the result
//   register has taken the frame from the input register, and one frame
//   is accepted every cycle when the receiver keeps up. Frames with an
//   unused format code are dropped with no result.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle:
//   index 0 is the sample format, index 1 the stereo mode.
//   Reset clears both pipeline stages and sets signed 16-bit stereo.
//   When the receiver stalls the result register holds its frame, the input
//   register fills behind it, and in_ready then drops until out_ready
//   returns; no frame is lost or repeated.
// ----------------------------------------------------------------------------
module pcm_frame_to_24bit_stereo (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [pfc_pkg::RAW_W-1:0]             left_raw,
	input  logic [pfc_pkg::RAW_W-1:0]             right_raw,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pfc_pkg::SAMPLE_W-1:0]   left_out,
	output logic signed [pfc_pkg::SAMPLE_W-1:0]   right_out,
	input  logic                                  cfg_we,
	input  logic [pfc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pfc_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import pfc_pkg::*;

	cfg_t                cfg;
	logic                valid_s1;
	logic [RAW_W-1:0]    left_raw_s1;
	logic [RAW_W-1:0]    right_raw_s1;
	logic                valid_s2;
	logic [SAMPLE_W-1:0] left_s2;
	logic [SAMPLE_W-1:0] right_s2;
	logic [SAMPLE_W-1:0] left_conv;
	logic [SAMPLE_W-1:0] right_conv;
	logic                s2_ready;
	logic                fmt_ok;

	pfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfc_conv u_conv_left (
		.sample_format (cfg.sample_format),
		.raw           (left_raw_s1),
		.sample        (left_conv)
	);

	pfc_conv u_conv_right (
		.sample_format (cfg.sample_format),
		.raw           (right_raw_s1),
		.sample        (right_conv)
	);

	// Stage handshakes: each stage advances when the next one can take it
	assign s2_ready = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s2_ready;
	assign fmt_ok   = (cfg.sample_format <= FMT_ULAW);

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			left_raw_s1  <= left_raw;
			right_raw_s1 <= right_raw;
		end
	end

	// Result register valid; drop frames with an unused format code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1 && fmt_ok;
		end
	end

	// Result register payload; duplicate left in mono mode
	always_ff @(posedge clk) begin
		if (valid_s1 && s2_ready) begin
			left_s2  <= left_conv;
			right_s2 <= cfg.stereo_mode ? right_conv : left_conv;
		end
	end

	assign out_valid = valid_s2;
	assign left_out  = left_s2;
	assign right_out = right_s2;

endmodule

// File: rtl/pfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pfc_cfg_regs
// Configuration register file: sample format and stereo mode.
// ----------------------------------------------------------------------------
module pfc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data,
	output pfc_pkg::cfg_t                  cfg
);
	import pfc_pkg::*;

	logic [2:0] sample_format_q;
	logic       stereo_mode_q;

	// Update the addressed register; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_format_q <= FMT_RESET;
			stereo_mode_q   <= STEREO_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_FORMAT: sample_format_q <= cfg_data[2:0];
				CFG_IDX_STEREO: stereo_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.sample_format = sample_format_q;
	assign cfg.stereo_mode   = stereo_mode_q;

endmodule

// File: rtl/pfc_conv.sv
// ----------------------------------------------------------------------------
// pfc_conv
// Converts one raw sample word to a 24-bit signed sample.
// ----------------------------------------------------------------------------
module pfc_conv (
	input  logic [2:0]                    sample_format,
	input  logic [pfc_pkg::RAW_W-1:0]     raw,
	output logic [pfc_pkg::SAMPLE_W-1:0]  sample
);
	import pfc_pkg::*;

	// Select the conversion for the configured format
	always_comb begin
		case (sample_format)
			FMT_U8:   sample = {raw[7:0] ^ U8_OFFSET, 16'd0};
			FMT_S16:  sample = {raw[15:0], 8'd0};
			FMT_S24:  sample = raw[23:0];
			FMT_S32:  sample = raw[31:8];
			FMT_ALAW: sample = {alaw_expand(raw[7:0]), 8'd0};
			FMT_ULAW: sample = {ulaw_expand(raw[7:0]), 8'd0};
			default:  sample = '0;
		endcase
	end

endmodule
